>>> rtl/csm_pkg.sv
// Shared widths, register indexes and reset values for the clearance map block.
package csm_pkg;

   // Field widths of the streamed words.
   localparam int unsigned COST_W  = 8;
   localparam int unsigned CLEAR_W = 9;

   // Configuration register widths.
   localparam int unsigned DIM_W = 9;
   localparam int unsigned THR_W = 8;

   // Configuration port shape.
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 9;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd2;

   // Register values after reset.
   localparam logic [DIM_W-1:0] WIDTH_RESET     = 9'd64;
   localparam logic [DIM_W-1:0] HEIGHT_RESET    = 9'd64;
   localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd10;

   // Default sizes of the map.
   localparam int unsigned MAX_HEIGHT_DEFAULT = 256;
   localparam int unsigned MAX_WIDTH_DEFAULT  = 256;

   // Clearance of a free cell on the first row or column of the scan.
   localparam logic [CLEAR_W-1:0] EDGE_CLEARANCE = 9'd1;

endpackage

>>> rtl/csm_cell.sv
// One cell of the column line: holds one clearance value and passes it on.
module csm_cell #(
   parameter int unsigned VAL_W = csm_pkg::CLEAR_W
) (
   input  logic             clock,
   input  logic             shift_en,
   input  logic             load_en,
   input  logic [VAL_W-1:0] new_val,
   input  logic [VAL_W-1:0] chain_in,
   output logic [VAL_W-1:0] chain_out
);

   logic [VAL_W-1:0] val_ff;
   logic [VAL_W-1:0] val_in;

   // Either start a fresh value here or take the neighbour's value.
   always_comb begin
      val_in = load_en ? new_val : chain_in;
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         val_ff <= val_in;
      end
   end

   assign chain_out = val_ff;

endmodule

>>> rtl/csm_column_line.sv
// Chain of cells that returns each clearance value exactly one column later.
module csm_column_line #(
   parameter int unsigned DEPTH = csm_pkg::MAX_HEIGHT_DEFAULT,
   parameter int unsigned VAL_W = csm_pkg::CLEAR_W
) (
   input  logic                     clock,
   input  logic                     shift_en,
   input  logic [$clog2(DEPTH)-1:0] ins_pos,
   input  logic [VAL_W-1:0]         new_val,
   output logic [VAL_W-1:0]         tap_out
);

   localparam int unsigned POS_W = $clog2(DEPTH);

   logic [VAL_W-1:0] chain [DEPTH];

   // A value enters at the insert position and moves one cell towards the far
   // end on each shift.
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic [VAL_W-1:0] link_in;

      if (k == 0) begin : g_head
         assign link_in = new_val;
      end else begin : g_body
         assign link_in = chain[k-1];
      end

      csm_cell #(
         .VAL_W (VAL_W)
      ) u_cell (
         .clock     (clock),
         .shift_en  (shift_en),
         .load_en   (ins_pos == POS_W'(k)),
         .new_val   (new_val),
         .chain_in  (link_in),
         .chain_out (chain[k])
      );
   end

   assign tap_out = chain[DEPTH-1];

endmodule

>>> rtl/clearance_square_map.sv
// Top level of the streaming maximal free square clearance map.
// A result word is registered and appears in the cycle after its cost word is accepted.
// Throughput: one word per cycle unless the result side stalls; the min-and-increment
// loop and the column line of cells both advance once per accepted word.
// Reset clears the scan counters and the output valid flag and restores the
// default configuration; the column line is not cleared, as column 0 never reads it.
module clearance_square_map #(
   parameter int unsigned MAX_HEIGHT = csm_pkg::MAX_HEIGHT_DEFAULT,
   parameter int unsigned MAX_WIDTH  = csm_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // Cost stream.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] cost
   // Clearance stream.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [15:0]                     rsp_tdata,   // [8:0] clearance, [15:9] zero
   output logic                            rsp_tlast,   // last cell of the map
   // Configuration writes.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [csm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [csm_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);
   localparam int unsigned COL_W = $clog2(MAX_WIDTH);
   localparam int unsigned HX_W  = (ROW_W + 1 > csm_pkg::DIM_W) ? ROW_W + 1 : csm_pkg::DIM_W;
   localparam int unsigned WX_W  = (COL_W + 1 > csm_pkg::DIM_W) ? COL_W + 1 : csm_pkg::DIM_W;
   localparam int unsigned CW    = csm_pkg::CLEAR_W;

   // Configuration registers.
   logic [csm_pkg::DIM_W-1:0] width_ff, width_in;
   logic [csm_pkg::DIM_W-1:0] height_ff, height_in;
   logic [csm_pkg::THR_W-1:0] thr_ff, thr_in;
   logic                      restart;

   // Scan state.
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [CW-1:0]    prev_ff, prev_in;
   logic [CW-1:0]    diag_ff, diag_in;

   // Output register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]    rsp_clear_ff, rsp_clear_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             accept;
   logic [HX_W-1:0]  height_x;
   logic [WX_W-1:0]  width_x;
   logic [ROW_W-1:0] h_last;
   logic [COL_W-1:0] w_last;
   logic [ROW_W-1:0] ins_pos;
   logic             end_col;
   logic             end_map;
   logic             blocked;
   logic [CW-1:0]    up_val;
   logic [CW-1:0]    min_a;
   logic [CW-1:0]    min_b;
   logic [CW-1:0]    cell_val;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // Register writes; a new dimension restarts the scan.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      thr_in    = thr_ff;
      restart   = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            csm_pkg::CSR_WIDTH: begin
               width_in = csr_data;
               restart  = 1'b1;
            end
            csm_pkg::CSR_HEIGHT: begin
               height_in = csr_data;
               restart   = 1'b1;
            end
            csm_pkg::CSR_THRESHOLD: begin
               thr_in = csr_data[csm_pkg::THR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Effective last row and column; zero means one, large values clamp.
   always_comb begin
      height_x = HX_W'(height_ff);
      width_x  = WX_W'(width_ff);
      priority if (height_x == '0) begin
         h_last = '0;
      end else if (height_x > HX_W'(MAX_HEIGHT)) begin
         h_last = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         h_last = ROW_W'(height_x - HX_W'(1));
      end
      priority if (width_x == '0) begin
         w_last = '0;
      end else if (width_x > WX_W'(MAX_WIDTH)) begin
         w_last = COL_W'(MAX_WIDTH - 1);
      end else begin
         w_last = COL_W'(width_x - WX_W'(1));
      end
      ins_pos = ROW_W'(MAX_HEIGHT - 1) - h_last;
   end

   // Column line: value of the same row in the previous column.
   csm_column_line #(
      .DEPTH (MAX_HEIGHT),
      .VAL_W (CW)
   ) u_line (
      .clock    (clock),
      .shift_en (accept),
      .ins_pos  (ins_pos),
      .new_val  (cell_val),
      .tap_out  (up_val)
   );

   // Cell value: blocked, edge, or one more than the smallest neighbour.
   always_comb begin
      blocked = req_tdata[csm_pkg::COST_W-1:0] > thr_ff;
      min_a   = (up_val < prev_ff) ? up_val : prev_ff;
      min_b   = (min_a < diag_ff) ? min_a : diag_ff;
      priority if (blocked) begin
         cell_val = '0;
      end else if (row_ff == '0 || col_ff == '0) begin
         cell_val = csm_pkg::EDGE_CLEARANCE;
      end else begin
         cell_val = min_b + CW'(1);
      end
      end_col = row_ff == h_last;
      end_map = end_col && (col_ff == w_last);
   end

   // Scan counters and neighbour registers.
   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      prev_in = prev_ff;
      diag_in = diag_ff;
      priority if (restart) begin
         row_in  = '0;
         col_in  = '0;
         prev_in = '0;
         diag_in = '0;
      end else if (accept) begin
         if (end_col) begin
            row_in  = '0;
            col_in  = end_map ? '0 : col_ff + COL_W'(1);
            prev_in = '0;
            diag_in = '0;
         end else begin
            row_in  = row_ff + ROW_W'(1);
            prev_in = cell_val;
            diag_in = up_val;
         end
      end
   end

   // Output register, refilled as soon as its word is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_clear_in = rsp_clear_ff;
      rsp_last_in  = rsp_last_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_clear_in = cell_val;
         rsp_last_in  = end_map;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= csm_pkg::WIDTH_RESET;
         height_ff    <= csm_pkg::HEIGHT_RESET;
         thr_ff       <= csm_pkg::THRESHOLD_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
         prev_ff      <= '0;
         diag_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         thr_ff       <= thr_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         prev_ff      <= prev_in;
         diag_ff      <= diag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_clear_ff <= rsp_clear_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16 - CW){1'b0}}, rsp_clear_ff};
   assign rsp_tlast  = rsp_last_ff;

   // An accepted word always leaves a result waiting in the next cycle.
   a_accept_gives_word: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("accepted cost word produced no result");

   // The final cell of a map sends the scan back to the first cell.
   a_map_wraps: assert property (@(posedge clock) disable iff (reset)
      (accept && end_map && !restart) |=> (row_ff == '0 && col_ff == '0))
      else $error("scan did not wrap after the last cell");

   // An interior free cell never exceeds its upper neighbour by more than one.
   a_interior_bound: assert property (@(posedge clock) disable iff (reset)
      (accept && !blocked && row_ff != '0 && col_ff != '0)
      |=> (rsp_clear_ff <= $past(prev_ff) + CW'(1)))
      else $error("interior clearance above neighbour plus one");

endmodule

>>> verif/clearance_square_map_test.sv
// Self-checking stream testbench for the clearance square map block.
module clearance_square_map_test;

   localparam int unsigned LINE_DEPTH   = csm_pkg::MAX_HEIGHT_DEFAULT;
   localparam int unsigned RANDOM_CELLS = 1800;
   localparam int unsigned CYCLE_LIMIT  = 600000;
   localparam int unsigned REPORT_CAP   = 200;

   // One result word as the block should emit it.
   typedef struct packed {
      logic [csm_pkg::CLEAR_W-1:0] clearance;
      logic                        last_cell;
   } cell_result_type;

   // One row of the directed script: a register write or a cost word.
   typedef enum logic {STEP_REG, STEP_CELL} step_kind_type;
   typedef struct {
      step_kind_type                  kind;
      logic [csm_pkg::CSR_IDX_W-1:0]  idx;
      logic [csm_pkg::CSR_DATA_W-1:0] data;
      logic [csm_pkg::COST_W-1:0]     cost;
      bit                             typed;
      cell_result_type                want;
   } step_type;

   logic                           clock;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [7:0]                     req_tdata  = '0;   // [7:0] cost
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [15:0]                    rsp_tdata;         // [8:0] clearance, [15:9] zero
   logic                           rsp_tlast;         // last cell of the map
   logic                           csr_valid  = 1'b0;
   logic                           csr_ready;
   logic [csm_pkg::CSR_IDX_W-1:0]  csr_index  = csm_pkg::CSR_WIDTH;
   logic [csm_pkg::CSR_DATA_W-1:0] csr_data   = '0;

   // Hand-typed expectation travelling alongside the current cost word.
   bit                             cell_typed = 1'b0;
   cell_result_type                cell_want  = '0;

   // Mirror of the block's configuration and scan state.
   logic [csm_pkg::DIM_W-1:0]      map_w       = csm_pkg::WIDTH_RESET;
   logic [csm_pkg::DIM_W-1:0]      map_h       = csm_pkg::HEIGHT_RESET;
   logic [csm_pkg::THR_W-1:0]      block_above = csm_pkg::THRESHOLD_RESET;
   logic [csm_pkg::CLEAR_W-1:0]    col_line [LINE_DEPTH] = '{default: '0};
   logic [csm_pkg::CLEAR_W-1:0]    run_prev    = '0;
   logic [csm_pkg::CLEAR_W-1:0]    corner      = '0;
   int unsigned                    col_pos     = 0;
   int unsigned                    row_pos     = 0;

   cell_result_type                clearance_q [$];
   step_type                       script [$];

   bit                    quiet        = 1'b0;
   int unsigned           hold_left    = 0;
   int unsigned           cycle_count  = 0;
   int unsigned           fail_count   = 0;
   int unsigned           cells_sent   = 0;
   int unsigned           reg_writes   = 0;
   int unsigned           maps_closed  = 0;
   int unsigned           peak_clear   = 0;

   clearance_square_map dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // A zero dimension counts as one, an oversized one as the line depth.
   function automatic int unsigned dim_eff(input logic [csm_pkg::DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > LINE_DEPTH) return LINE_DEPTH;
      return v;
   endfunction

   // Clearance of the next cell in scan order; advances the mirror state.
   function automatic cell_result_type next_clearance(
      input logic [csm_pkg::COST_W-1:0] cost);
      cell_result_type             res;
      logic [csm_pkg::CLEAR_W-1:0] above;
      logic [csm_pkg::CLEAR_W-1:0] low;
      logic [csm_pkg::CLEAR_W-1:0] val;
      bit                          col_done;
      above = col_line[row_pos];
      if (cost > block_above) begin
         val = '0;
      end else if (col_pos == 0 || row_pos == 0) begin
         val = csm_pkg::EDGE_CLEARANCE;
      end else begin
         low = (above < run_prev) ? above : run_prev;
         low = (low < corner) ? low : corner;
         val = low + 1'b1;
      end
      corner = above;
      col_line[row_pos] = val;
      run_prev = val;
      col_done = (row_pos + 1 >= dim_eff(map_h));
      res.clearance = val;
      res.last_cell = col_done && (col_pos + 1 >= dim_eff(map_w));
      if (col_done) begin
         row_pos = 0;
         run_prev = '0;
         corner = '0;
         col_pos = res.last_cell ? 0 : col_pos + 1;
      end else begin
         row_pos = row_pos + 1;
      end
      return res;
   endfunction

   // Gap length for either side: mostly none or short, now and then long.
   function automatic int unsigned idle_len();
      int unsigned roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Cost biased towards free cells so that squares can grow.
   function automatic logic [csm_pkg::COST_W-1:0] pick_cost(input int unsigned thr,
                                                            input int unsigned block_pct,
                                                            input bit noise);
      if (noise) return csm_pkg::COST_W'($urandom_range(0, 255));
      if (thr != 255 && $urandom_range(0, 99) < block_pct)
         return csm_pkg::COST_W'($urandom_range(thr + 1, 255));
      return csm_pkg::COST_W'($urandom_range(0, thr));
   endfunction

   function automatic step_type reg_step(input logic [csm_pkg::CSR_IDX_W-1:0] idx,
                                         input logic [csm_pkg::CSR_DATA_W-1:0] data);
      step_type s;
      s = '{kind: STEP_REG, idx: idx, data: data, cost: '0, typed: 1'b0, want: '0};
      return s;
   endfunction

   function automatic step_type cell_step(input logic [csm_pkg::COST_W-1:0] cost);
      step_type s;
      s = '{kind: STEP_CELL, idx: csm_pkg::CSR_WIDTH, data: '0, cost: cost, typed: 1'b0,
            want: '0};
      return s;
   endfunction

   function automatic step_type known_step(input logic [csm_pkg::COST_W-1:0] cost,
                                           input logic [csm_pkg::CLEAR_W-1:0] clear,
                                           input logic last);
      step_type s;
      s = '{kind: STEP_CELL, idx: csm_pkg::CSR_WIDTH, data: '0, cost: cost, typed: 1'b1,
            want: '{clearance: clear, last_cell: last}};
      return s;
   endfunction

   // Offer one cost word after a random gap and wait for it to be taken.
   task automatic push_cell(input logic [csm_pkg::COST_W-1:0] cost, input bit typed,
                            input cell_result_type want);
      int unsigned gap;
      gap = idle_len();
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= cost;
      cell_typed <= typed;
      cell_want  <= want;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      cells_sent++;
   endtask

   // Stop offering words and wait until every expected word has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (clearance_q.size() != 0) @(negedge clock);
   endtask

   // Register write, issued only once the block has gone quiet.
   task automatic write_reg(input logic [csm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [csm_pkg::CSR_DATA_W-1:0] data);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
      reg_writes++;
   endtask

   // Result side backpressure: occasional stalls of random length.
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         hold_left  <= ($urandom_range(0, 3) == 0) ? idle_len() : 0;
      end
   end

   // Mirror register writes, predict accepted words and check returned ones.
   always @(posedge clock) begin
      cell_result_type want;
      logic [15:0]     want_word;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run timed out with %0d words outstanding", $time, clearance_q.size());
         $display("status: fail");
         $finish;
      end else if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               csm_pkg::CSR_WIDTH, csm_pkg::CSR_HEIGHT: begin
                  if (csr_index == csm_pkg::CSR_WIDTH) map_w = csr_data;
                  else map_h = csr_data;
                  // A new dimension starts a fresh map at its first cell.
                  run_prev = '0;
                  corner   = '0;
                  col_pos  = 0;
                  row_pos  = 0;
               end
               csm_pkg::CSR_THRESHOLD: block_above = csr_data[csm_pkg::THR_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            want = next_clearance(req_tdata[csm_pkg::COST_W-1:0]);
            if (cell_typed) want = cell_want;
            clearance_q.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_tdata[csm_pkg::CLEAR_W-1:0] > peak_clear)
               peak_clear = rsp_tdata[csm_pkg::CLEAR_W-1:0];
            if (rsp_tlast === 1'b1) maps_closed++;
            if (clearance_q.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_CAP)
                  $display("%0t: unexpected clearance word: expected none, got tdata %h last %b",
                           $time, rsp_tdata, rsp_tlast);
            end else begin
               want = clearance_q.pop_front();
               want_word = 16'(want.clearance);
               if (rsp_tdata !== want_word || rsp_tlast !== want.last_cell) begin
                  fail_count++;
                  if (fail_count <= REPORT_CAP)
                     $display("%0t: mismatch: expected tdata %h last %b, got tdata %h last %b",
                              $time, want_word, want.last_cell, rsp_tdata, rsp_tlast);
               end
            end
         end
      end
   end

   initial begin
      int unsigned  directed_cells;
      int unsigned  random_cells;
      int unsigned  cur_thr;
      int unsigned  block_pct;
      int unsigned  count;
      int unsigned  cells;
      bit           noise;
      logic [8:0]   w;
      logic [8:0]   h;
      logic [8:0]   thr_word;

      // Directed script: defaults after reset, threshold edges, dimension
      // edges and a restart of the scan in the middle of a map.
      script.push_back(known_step(8'd0,   9'd1, 1'b0));
      script.push_back(known_step(8'd255, 9'd0, 1'b0));
      script.push_back(known_step(8'd10,  9'd1, 1'b0));
      script.push_back(known_step(8'd11,  9'd0, 1'b0));
      script.push_back(reg_step(csm_pkg::CSR_WIDTH,  9'd2));
      script.push_back(reg_step(csm_pkg::CSR_HEIGHT, 9'd2));
      script.push_back(known_step(8'd10, 9'd1, 1'b0));
      script.push_back(known_step(8'd0,  9'd1, 1'b0));
      script.push_back(known_step(8'd5,  9'd1, 1'b0));
      script.push_back(known_step(8'd3,  9'd2, 1'b1));
      script.push_back(reg_step(csm_pkg::CSR_THRESHOLD, 9'd0));
      script.push_back(known_step(8'd0, 9'd1, 1'b0));
      script.push_back(known_step(8'd1, 9'd0, 1'b0));
      script.push_back(known_step(8'd0, 9'd1, 1'b0));
      script.push_back(known_step(8'd0, 9'd1, 1'b1));
      script.push_back(reg_step(csm_pkg::CSR_THRESHOLD, 9'h0FF));
      repeat (4) script.push_back(cell_step(8'd255));
      // Zero dimensions give a one-cell map.
      script.push_back(reg_step(csm_pkg::CSR_WIDTH,  9'd0));
      script.push_back(reg_step(csm_pkg::CSR_HEIGHT, 9'd0));
      script.push_back(known_step(8'd200, 9'd1, 1'b1));
      // An oversized width is clamped to the full line.
      script.push_back(reg_step(csm_pkg::CSR_WIDTH,  9'h1FF));
      script.push_back(reg_step(csm_pkg::CSR_HEIGHT, 9'd1));
      script.push_back(cell_step(8'd7));
      script.push_back(cell_step(8'd7));
      // Threshold bit 8 is ignored; a height write part way through restarts.
      script.push_back(reg_step(csm_pkg::CSR_WIDTH,     9'd3));
      script.push_back(reg_step(csm_pkg::CSR_HEIGHT,    9'd3));
      script.push_back(reg_step(csm_pkg::CSR_THRESHOLD, 9'h114));
      script.push_back(cell_step(8'd20));
      script.push_back(cell_step(8'd21));
      script.push_back(cell_step(8'd0));
      script.push_back(cell_step(8'd5));
      script.push_back(reg_step(csm_pkg::CSR_HEIGHT, 9'd3));
      script.push_back(known_step(8'd0, 9'd1, 1'b0));
      script.push_back(known_step(8'd0, 9'd1, 1'b0));

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      cur_thr = csm_pkg::THRESHOLD_RESET;
      foreach (script[i]) begin
         if (script[i].kind == STEP_REG) begin
            write_reg(script[i].idx, script[i].data);
            if (script[i].idx == csm_pkg::CSR_THRESHOLD)
               cur_thr = script[i].data[csm_pkg::THR_W-1:0];
         end else begin
            push_cell(script[i].cost, script[i].typed, script[i].want);
         end
      end
      directed_cells = cells_sent;

      // Random phases: mostly whole maps of small size with free-biased costs,
      // a few at the dimension extremes, and some threshold-only changes that
      // leave the scan where it was.
      random_cells = 0;
      while (random_cells < RANDOM_CELLS) begin
         quiet     = ($urandom_range(0, 5) == 0);
         noise     = ($urandom_range(0, 7) == 0);
         block_pct = $urandom_range(0, 30);
         case ($urandom_range(0, 7))
            0: thr_word = {1'($urandom_range(0, 1)), 8'd0};
            1: thr_word = {1'($urandom_range(0, 1)), 8'd255};
            default: thr_word = 9'($urandom_range(0, 511));
         endcase
         if ($urandom_range(0, 4) == 0) begin
            write_reg(csm_pkg::CSR_THRESHOLD, thr_word);
            cur_thr = thr_word[csm_pkg::THR_W-1:0];
            count = $urandom_range(1, 40);
         end else begin
            case ($urandom_range(0, 9))
               0: begin
                  w = 9'($urandom_range(256, 511));
                  h = 9'($urandom_range(1, 2));
               end
               1: begin
                  h = 9'($urandom_range(256, 511));
                  w = 9'($urandom_range(1, 2));
               end
               2: begin
                  w = 9'($urandom_range(0, 1));
                  h = 9'($urandom_range(0, 4));
               end
               3: begin
                  h = '0;
                  w = 9'($urandom_range(0, 6));
               end
               default: begin
                  w = 9'($urandom_range(1, 12));
                  h = 9'($urandom_range(1, 12));
               end
            endcase
            if ($urandom_range(0, 1) == 0) begin
               write_reg(csm_pkg::CSR_WIDTH, w);
               write_reg(csm_pkg::CSR_HEIGHT, h);
            end else begin
               write_reg(csm_pkg::CSR_HEIGHT, h);
               write_reg(csm_pkg::CSR_WIDTH, w);
            end
            if ($urandom_range(0, 2) != 0) begin
               write_reg(csm_pkg::CSR_THRESHOLD, thr_word);
               cur_thr = thr_word[csm_pkg::THR_W-1:0];
            end
            cells = dim_eff(w) * dim_eff(h);
            count = cells * ((cells > 64) ? 1 : $urandom_range(1, 3));
            // Sometimes stop part way through a map so the next write restarts it.
            if (cells > 1 && $urandom_range(0, 2) == 0) count += $urandom_range(1, cells - 1);
         end
         // Keep the total number of random words close to the planned figure.
         if (count > RANDOM_CELLS - random_cells) count = RANDOM_CELLS - random_cells;
         repeat (count) begin
            push_cell(pick_cost(cur_thr, block_pct, noise), 1'b0, '0);
            random_cells++;
         end
      end

      // Let the last words come back, then allow the pipeline to settle.
      quiet = 1'b1;
      wait_drained();
      repeat (4) @(negedge clock);
      if (clearance_q.size() != 0) begin
         fail_count++;
         $display("%0t: %0d expected words never returned", $time, clearance_q.size());
      end

      $display("Covered %0d cost words (%0d directed) over %0d register writes.",
               cells_sent, directed_cells, reg_writes);
      $display("Closed %0d maps, largest clearance %0d, %0d mismatches.",
               maps_closed, peak_clear, fail_count);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
